// ===== hw/rtl/triangle_face_normal_top_macros.svh =====
// Assertion macros for the triangle face normal block.
// Included by the modules that carry assertions; expects clk and arst_n in scope.
`ifndef TRIANGLE_FACE_NORMAL_TOP_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TFN_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define TFN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tfn_pkg.sv =====
// Shared types and constants for the triangle face normal pipeline.
// No dependencies.
package tfn_pkg;

	// scaled component magnitude width after block scaling
	localparam int UW = 31;
	// sum of squares and vector length widths
	localparam int SUM_W = 64;
	localparam int LEN_W = 32;
	// fraction bits added before the divide, quotient width
	localparam int FRAC_SH = 16;
	localparam int Q_W = 16;
	localparam int NUM_W = UW + FRAC_SH + 1;
	localparam int DEN_W = LEN_W + 1;
	// output component width
	localparam int NRM_W = 16;
	localparam logic [Q_W-1:0] Q_POS_MAX = 16'h7FFF;

	typedef logic [UW-1:0] umag_t;
	typedef logic signed [NRM_W-1:0] nrm_t;

	// per-word flags that ride along the pipeline
	typedef struct packed {
		logic       deg;
		logic [2:0] neg;
	} flags_t;

	// sideband through the square root: flags and scaled magnitudes
	typedef struct packed {
		flags_t    f;
		umag_t [2:0] u;
	} sq_side_t;

endpackage

// ===== hw/rtl/tfn_ifs.sv =====
// Valid/ready channel interfaces for the triangle face normal block.
// Depends on tfn_pkg.
interface tfn_tri_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic signed [W-1:0] a_x, a_y, a_z;
	logic signed [W-1:0] b_x, b_y, b_z;
	logic signed [W-1:0] c_x, c_y, c_z;

	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		input ready);
	modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		output ready);
endinterface

interface tfn_nrm_if;
	logic valid;
	logic ready;
	tfn_pkg::nrm_t normal_x, normal_y, normal_z;
	logic degenerate;

	modport source (output valid, normal_x, normal_y, normal_z, degenerate,
		input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, degenerate,
		output ready);
endinterface

// ===== hw/rtl/triangle_face_normal_top.sv =====
// Triangle face normal: cross product of (b-a) and (b-c), normalized to Q1.15.
// One triangle per cycle while the output word is free or being taken.
// Fully pipelined path: 8 front stages, 32-stage square root, 16-stage
// divider, output register. One global enable stalls all stages.
// Reset (arst_n low, async) clears every valid bit; no clearing pass needed.
module triangle_face_normal_top #(
	parameter int COORD_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	tfn_tri_if.sink    tri_in,
	tfn_nrm_if.source  nrm_out
);
	`include "triangle_face_normal_top_macros.svh"

	localparam int W  = COORD_WIDTH;
	localparam int EW = W + 1;
	localparam int PW = 2 * EW;
	localparam int CW = 2 * W + 3;
	localparam int KW = $clog2(CW + 1);
	localparam int UW = tfn_pkg::UW;

	logic en;

	// whole pipe advances when the output word is free or being taken
	assign en = !nrm_out.valid || nrm_out.ready;
	assign tri_in.ready = en;

	// stage 1: edges
	logic                vld_s1;
	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= tri_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e1_s1[0] <= EW'(tri_in.b_x) - EW'(tri_in.a_x);
			e1_s1[1] <= EW'(tri_in.b_y) - EW'(tri_in.a_y);
			e1_s1[2] <= EW'(tri_in.b_z) - EW'(tri_in.a_z);
			e2_s1[0] <= EW'(tri_in.b_x) - EW'(tri_in.c_x);
			e2_s1[1] <= EW'(tri_in.b_y) - EW'(tri_in.c_y);
			e2_s1[2] <= EW'(tri_in.b_z) - EW'(tri_in.c_z);
		end
	end

	// stage 2: six partial products
	logic                vld_s2;
	logic signed [PW-1:0] p_s2 [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= e1_s1[1] * e2_s1[2];
			p_s2[1] <= e1_s1[2] * e2_s1[1];
			p_s2[2] <= e1_s1[2] * e2_s1[0];
			p_s2[3] <= e1_s1[0] * e2_s1[2];
			p_s2[4] <= e1_s1[0] * e2_s1[1];
			p_s2[5] <= e1_s1[1] * e2_s1[0];
		end
	end

	// stage 3: cross product components
	logic                vld_s3;
	logic signed [CW-1:0] cr_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				cr_s3[i] <= CW'(p_s2[2*i]) - CW'(p_s2[2*i+1]);
			end
		end
	end

	// stage 4: sign and magnitude, OR of magnitudes
	logic          vld_s4;
	logic [CW-1:0] mg_s4 [3];
	logic [2:0]    neg_s4;
	logic [CW-1:0] or_s4;
	logic [CW-1:0] mg_c  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mg_c[i] = cr_s3[i][CW-1] ? CW'(-cr_s3[i]) : CW'(cr_s3[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mg_s4[i]  <= mg_c[i];
				neg_s4[i] <= cr_s3[i][CW-1];
			end
			or_s4 <= mg_c[0] | mg_c[1] | mg_c[2];
		end
	end

	// stage 5: bit length of the largest magnitude
	logic            vld_s5;
	logic [CW-1:0]   mg_s5 [3];
	tfn_pkg::flags_t fl_s5;
	logic [KW-1:0]   k_s5;
	logic [KW-1:0]   k_c;

	always_comb begin
		k_c = '0;
		for (int i = 0; i < CW; i++) begin
			if (or_s4[i]) begin
				k_c = KW'(i + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mg_s5     <= mg_s4;
			fl_s5.neg <= neg_s4;
			fl_s5.deg <= (or_s4 == '0);
			k_s5      <= k_c;
		end
	end

	// stage 6: block scaling so the largest magnitude has UW bits
	logic            vld_s6;
	tfn_pkg::flags_t fl_s6;
	tfn_pkg::umag_t  u_s6 [3];
	logic [CW+UW-1:0] sh_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh_c[i] = {mg_s5[i], {UW{1'b0}}} >> k_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s6 <= fl_s5;
			for (int i = 0; i < 3; i++) begin
				u_s6[i] <= sh_c[i][UW-1:0];
			end
		end
	end

	// stage 7: squares
	logic            vld_s7;
	tfn_pkg::flags_t fl_s7;
	tfn_pkg::umag_t  u_s7  [3];
	logic [2*UW-1:0] sq_s7 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s7 <= fl_s6;
			u_s7  <= u_s6;
			for (int i = 0; i < 3; i++) begin
				sq_s7[i] <= u_s6[i] * u_s6[i];
			end
		end
	end

	// stage 8: sum of squares
	logic                      vld_s8;
	tfn_pkg::sq_side_t         side_s8;
	logic [tfn_pkg::SUM_W-1:0] sum_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s8.f <= fl_s7;
			for (int i = 0; i < 3; i++) begin
				side_s8.u[i] <= u_s7[i];
			end
			sum_s8 <= tfn_pkg::SUM_W'(sq_s7[0]) + tfn_pkg::SUM_W'(sq_s7[1])
				+ tfn_pkg::SUM_W'(sq_s7[2]);
		end
	end

	// vector length
	logic                      sq_vld;
	tfn_pkg::sq_side_t         sq_side;
	logic [tfn_pkg::LEN_W-1:0] len;

	tfn_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s8),
		.side_i (side_s8),
		.x_i    (sum_s8),
		.vld_o  (sq_vld),
		.side_o (sq_side),
		.root_o (len)
	);

	// per-component rounded divide
	logic                         dv_vld;
	tfn_pkg::flags_t              dv_flags;
	logic [2:0][tfn_pkg::Q_W-1:0] dv_q;

	tfn_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_i   (sq_vld),
		.flags_i (sq_side.f),
		.u_i     (sq_side.u),
		.len_i   (len),
		.vld_o   (dv_vld),
		.flags_o (dv_flags),
		.q_o     (dv_q)
	);

	// output stage: sign, saturation, degenerate override
	logic            vld_q;
	logic            deg_q;
	tfn_pkg::nrm_t   nrm_q [3];
	tfn_pkg::nrm_t   nrm_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv_flags.deg) begin
				nrm_c[i] = '0;
			end else if (dv_flags.neg[i]) begin
				nrm_c[i] = tfn_pkg::nrm_t'(-dv_q[i]);
			end else if (dv_q[i] > tfn_pkg::Q_POS_MAX) begin
				nrm_c[i] = tfn_pkg::nrm_t'(tfn_pkg::Q_POS_MAX);
			end else begin
				nrm_c[i] = tfn_pkg::nrm_t'(dv_q[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg_q <= dv_flags.deg;
			nrm_q <= nrm_c;
		end
	end

	assign nrm_out.valid      = vld_q;
	assign nrm_out.degenerate = deg_q;
	assign nrm_out.normal_x   = nrm_q[0];
	assign nrm_out.normal_y   = nrm_q[1];
	assign nrm_out.normal_z   = nrm_q[2];

	// checks
	`TFN_ASSERT_IMPL(a_deg_zero, nrm_out.valid && nrm_out.degenerate,
		nrm_out.normal_x == '0 && nrm_out.normal_y == '0 && nrm_out.normal_z == '0,
		"degenerate word with nonzero normal")
	`TFN_ASSERT_IMPL(a_len_range, sq_vld && !sq_side.f.deg,
		len[tfn_pkg::LEN_W-1 -: 2] != 2'b00,
		"scaled length below 2^30")
	`TFN_ASSERT_NEXT(a_stall_hold, vld_s1 && !en, vld_s1,
		"stage 1 word lost during stall")

endmodule

// ===== hw/rtl/tfn_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, 32 stages.
// Depends on tfn_pkg.
module tfn_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_i,
	input  tfn_pkg::sq_side_t          side_i,
	input  logic [tfn_pkg::SUM_W-1:0]  x_i,
	output logic                       vld_o,
	output tfn_pkg::sq_side_t          side_o,
	output logic [tfn_pkg::LEN_W-1:0]  root_o
);
	localparam int N = tfn_pkg::LEN_W;
	localparam int RW = tfn_pkg::LEN_W + 3;

	logic                      vld_s  [0:N];
	tfn_pkg::sq_side_t         side_s [0:N];
	logic [tfn_pkg::SUM_W-1:0] x_s    [0:N];
	logic [RW-1:0]             rem_s  [0:N];
	logic [N-1:0]              root_s [0:N];

	assign vld_s[0]  = vld_i;
	assign side_s[0] = side_i;
	assign x_s[0]    = x_i;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar g = 0; g < N; g++) begin : g_stage
		logic [RW-1:0] rem_n, trial;
		logic          take;

		// bring down the next bit pair, try root*4+1
		always_comb begin
			rem_n = {rem_s[g][RW-3:0], x_s[g][tfn_pkg::SUM_W-1 -: 2]};
			trial = {1'b0, root_s[g], 2'b01};
			take  = (rem_n >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[g+1] <= side_s[g];
				x_s[g+1]    <= {x_s[g][tfn_pkg::SUM_W-3:0], 2'b00};
				rem_s[g+1]  <= take ? rem_n - trial : rem_n;
				root_s[g+1] <= {root_s[g][N-2:0], take};
			end
		end
	end

	assign vld_o  = vld_s[N];
	assign side_o = side_s[N];
	assign root_o = root_s[N];

endmodule

// ===== hw/rtl/tfn_div.sv =====
// Pipelined three-lane restoring divider, one quotient bit per stage.
// Forms round((u * 2^15) / len) as floor((u*2^16 + len) / (2*len)). Depends on tfn_pkg.
module tfn_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_i,
	input  tfn_pkg::flags_t            flags_i,
	input  tfn_pkg::umag_t [2:0]       u_i,
	input  logic [tfn_pkg::LEN_W-1:0]  len_i,
	output logic                       vld_o,
	output tfn_pkg::flags_t            flags_o,
	output logic [2:0][tfn_pkg::Q_W-1:0] q_o
);
	localparam int N  = tfn_pkg::Q_W;
	localparam int NW = tfn_pkg::NUM_W;
	localparam int DW = tfn_pkg::DEN_W;
	localparam int CW = DW + N;

	logic                     vld_s   [0:N];
	tfn_pkg::flags_t          flags_s [0:N];
	logic [DW-1:0]            den_s   [0:N];
	logic [2:0][NW-1:0]       rem_s   [0:N];
	logic [2:0][N-1:0]        q_s     [0:N];

	// numerators and shared denominator
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			rem_s[0][l] = {1'b0, u_i[l], {tfn_pkg::FRAC_SH{1'b0}}}
				+ NW'(len_i);
		end
	end
	assign vld_s[0]   = vld_i;
	assign flags_s[0] = flags_i;
	assign den_s[0]   = {len_i, 1'b0};
	assign q_s[0]     = '0;

	for (genvar g = 0; g < N; g++) begin : g_stage
		localparam int SH = N - 1 - g;
		logic [CW-1:0]      dsh;
		logic [2:0]         take;
		logic [2:0][NW-1:0] rem_n;

		// compare each lane against den << SH
		always_comb begin
			dsh = CW'(den_s[g]) << SH;
			for (int l = 0; l < 3; l++) begin
				take[l]  = (CW'(rem_s[g][l]) >= dsh);
				rem_n[l] = take[l] ? rem_s[g][l] - dsh[NW-1:0] : rem_s[g][l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				flags_s[g+1] <= flags_s[g];
				den_s[g+1]   <= den_s[g];
				rem_s[g+1]   <= rem_n;
				for (int l = 0; l < 3; l++) begin
					q_s[g+1][l] <= {q_s[g][l][N-2:0], take[l]};
				end
			end
		end
	end

	assign vld_o   = vld_s[N];
	assign flags_o = flags_s[N];
	assign q_o     = q_s[N];

endmodule

// ===== verif/triangle_face_normal_tb.sv =====
// Self-checking testbench for the triangle face normal block.
// Depends on tfn_pkg, tfn_ifs and triangle_face_normal_top from the RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 32;

	typedef struct {
		logic signed [15:0] nx, ny, nz;
		logic               deg;
	} normal_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tfn_tri_if #(.W(CW)) tri_ch();
	tfn_nrm_if nrm_ch();

	triangle_face_normal_top #(.COORD_WIDTH(CW)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.tri_in(tri_ch.sink),
		.nrm_out(nrm_ch.source)
	);

	normal_t expected_normals[$];
	int mismatches = 0;
	int send_idle_pct = 16;
	int recv_idle_pct = 16;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Exact integer square root, floor.
	function automatic logic [63:0] isqrt(input logic [63:0] x);
		logic [63:0] res, bitv, rem;
		res = 0;
		rem = x;
		bitv = 64'd1 << 62;
		while (bitv > rem)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Unit normal of triangle a,b,c: cross of (b-a) and (b-c), block scaled to 31 bits.
	function automatic normal_t face_normal(input logic signed [CW-1:0] v[9]);
		logic signed [CW:0] e1[3], e2[3];
		logic signed [127:0] cr[3];
		logic [127:0] mg[3];
		logic [63:0] u[3], sum, len, q;
		logic neg[3];
		int kmax, k;
		normal_t r;
		logic signed [15:0] comp[3];
		for (int i = 0; i < 3; i++) begin
			e1[i] = {v[3+i][CW-1], v[3+i]} - {v[i][CW-1], v[i]};
			e2[i] = {v[3+i][CW-1], v[3+i]} - {v[6+i][CW-1], v[6+i]};
		end
		cr[0] = 128'(e1[1]) * 128'(e2[2]) - 128'(e1[2]) * 128'(e2[1]);
		cr[1] = 128'(e1[2]) * 128'(e2[0]) - 128'(e1[0]) * 128'(e2[2]);
		cr[2] = 128'(e1[0]) * 128'(e2[1]) - 128'(e1[1]) * 128'(e2[0]);
		kmax = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = cr[i][127];
			mg[i] = neg[i] ? -cr[i] : cr[i];
			k = 0;
			for (int b = 0; b < 128; b++)
				if (mg[i][b]) k = b + 1;
			if (k > kmax) kmax = k;
		end
		if (kmax == 0) begin
			r.nx = 0; r.ny = 0; r.nz = 0; r.deg = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			if (kmax > 31) u[i] = 64'(mg[i] >> (kmax - 31));
			else u[i] = 64'(mg[i] << (31 - kmax));
		end
		sum = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
		len = isqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((u[i] << 16) + len) / (2 * len);
			if (neg[i]) comp[i] = 16'(-q);
			else comp[i] = (q > 64'd32767) ? 16'sd32767 : 16'(q);
		end
		r.nx = comp[0]; r.ny = comp[1]; r.nz = comp[2]; r.deg = 1'b0;
		return r;
	endfunction

	// Send one triangle; predict on acceptance. Valid stays up until the
	// next call, which drives at the following falling edge.
	task automatic send_triangle(input logic signed [CW-1:0] v[9]);
		@(negedge clk);
		while (($urandom_range(99)) < send_idle_pct) begin
			tri_ch.valid <= 1'b0;
			@(negedge clk);
		end
		tri_ch.valid <= 1'b1;
		{tri_ch.a_x, tri_ch.a_y, tri_ch.a_z} <= {v[0], v[1], v[2]};
		{tri_ch.b_x, tri_ch.b_y, tri_ch.b_z} <= {v[3], v[4], v[5]};
		{tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} <= {v[6], v[7], v[8]};
		@(posedge clk);
		while (!tri_ch.ready) @(posedge clk);
		expected_normals = {expected_normals, face_normal(v)};
	endtask

	// Random coordinate, mostly modest, sometimes full range.
	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed(32'($urandom_range(255))) - 128;
			default: return $signed($urandom) >>> $urandom_range(24);
		endcase
	endfunction

	// Extremes, zero edges, axis-aligned and collinear cases.
	task automatic test_directed();
		logic signed [CW-1:0] v[9];
		logic signed [CW-1:0] mx, mn;
		mx = 32'sh7FFFFFFF;
		mn = 32'sh80000000;
		v = '{default: 0};
		send_triangle(v);
		v = '{0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0};
		send_triangle(v);
		v = '{0, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
		send_triangle(v);
		v = '{0, 0, 0, 0, 0, 32'sh10000, 32'sh10000, 0, 0};
		send_triangle(v);
		v = '{mn, mn, mn, mx, mx, mx, mn, mx, mn};
		send_triangle(v);
		v = '{mx, mn, mx, mn, mx, mn, mx, mx, mn};
		send_triangle(v);
		v = '{mn, mn, mn, mx, mx, mx, mx, mx, mx};
		send_triangle(v);
		v = '{1, 2, 3, 2, 4, 6, 3, 6, 9};
		send_triangle(v);
		v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
		send_triangle(v);
		v = '{0, 0, 0, 0, 1, 0, 1, 0, 0};
		send_triangle(v);
		v = '{-1, -1, -1, mx, 0, mn, 0, mx, -1};
		send_triangle(v);
		v = '{mx, mx, mx, mn, mn, mn, 0, 0, 0};
		send_triangle(v);
		v = '{5, 5, 5, 5, 5, 5, 9, 1, 7};
		send_triangle(v);
		v = '{32'sh5555AAAA, 32'shAAAA5555, 32'sh0F0F0F0F, 32'shF0F0F0F0,
			32'sh33333333, 32'shCCCCCCCC, 1, -1, 0};
		send_triangle(v);
	endtask

	// Random triangles; a middle stretch runs with no idling.
	task automatic test_random(input int count);
		logic signed [CW-1:0] v[9];
		for (int n = 0; n < count; n++) begin
			if (n == count / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (n == count / 2) begin
				send_idle_pct = 16;
				recv_idle_pct = 16;
			end
			for (int i = 0; i < 9; i++) v[i] = rand_coord();
			// occasional collinear or repeated vertex
			if ($urandom_range(19) == 0) for (int i = 0; i < 3; i++) v[6+i] = v[i];
			send_triangle(v);
		end
	endtask

	// Output ready with random stalls.
	always @(negedge clk)
		nrm_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

	// Compare each accepted word with the oldest prediction.
	always @(posedge clk) begin
		normal_t exp_n;
		if (arst_n && nrm_ch.valid && nrm_ch.ready) begin
			if (expected_normals.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected output word");
			end else begin
				exp_n = expected_normals.pop_front();
				if (nrm_ch.normal_x !== exp_n.nx || nrm_ch.normal_y !== exp_n.ny ||
					nrm_ch.normal_z !== exp_n.nz || nrm_ch.degenerate !== exp_n.deg) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %0d %0d %0d %b got %0d %0d %0d %b",
							exp_n.nx, exp_n.ny, exp_n.nz, exp_n.deg, nrm_ch.normal_x,
							nrm_ch.normal_y, nrm_ch.normal_z, nrm_ch.degenerate);
				end
			end
		end
	end

	initial begin
		tri_ch.valid = 1'b0;
		{tri_ch.a_x, tri_ch.a_y, tri_ch.a_z} = '0;
		{tri_ch.b_x, tri_ch.b_y, tri_ch.b_z} = '0;
		{tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} = '0;
		nrm_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(1640);
		@(negedge clk);
		tri_ch.valid <= 1'b0;
		while (expected_normals.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatches == 0 && expected_normals.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tfn_pkg.sv
hw/rtl/tfn_ifs.sv
hw/rtl/tfn_sqrt.sv
hw/rtl/tfn_div.sv
hw/rtl/triangle_face_normal_top.sv
verif/triangle_face_normal_tb.sv
